// File: hw/rtl/pmic_arbiter_channel_lookup_top_macros.svh
// assertion helpers shared by the checker
`ifndef PMIC_ARBITER_CHANNEL_LOOKUP_TOP_MACROS_SVH
`define PMIC_ARBITER_CHANNEL_LOOKUP_TOP_MACROS_SVH

// checked outside reset
`define PACL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// checked also while reset is high
`define PACL_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// File: hw/rtl/pacl_pkg.sv
package pacl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 128;
  localparam int ENTRY_SPAN          = 128;

  localparam int OP_W      = 2;
  localparam int INDEX_W   = 7;
  localparam int WORD_W    = 32;
  localparam int OWNER_W   = 3;
  localparam int ADDR_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 28;
  localparam int PID_W     = 12;
  localparam int SLAVE_W   = 4;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  localparam logic [WORD_W-1:0] READ_BASE    = 32'h0E60_0000;
  localparam logic [WORD_W-1:0] WRITE_BASE   = 32'h0C60_0000;
  localparam int                READ_SHIFT   = 7;
  localparam int                WRITE_SHIFT  = 16;
  localparam int                OPCODE_BIT   = 27;
  localparam int                ADDR_LO_BIT  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ID       = 1'd1;

  localparam logic [SLAVE_W-1:0] SLAVE_ID_RESET = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MAP   = 2'd0,
    OP_LOAD_OWNER = 2'd1,
    OP_READ       = 2'd2,
    OP_WRITE      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_DENIED    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic in_is_lookup;
    logic issue_done;
    logic hit;
    logic rd_pending;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/pacl_ctrl.sv
module pacl_ctrl
  import pacl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = stat.in_is_lookup ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.issue = !stat.issue_done && !stat.hit;
        // wait for the last read in flight to be judged
        if (stat.hit || (stat.issue_done && !stat.rd_pending)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pacl_datapath.sv
module pacl_datapath
  import pacl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [OP_W-1:0]      operation,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [WORD_W-1:0]    map_word,
  input  logic [OWNER_W-1:0]   owner_code,
  input  logic [ADDR_W-1:0]    register_address,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [INDEX_W-1:0]   found_index,
  output logic [WORD_W-1:0]    channel_address,
  output logic [CMD_W-1:0]     command_word
);

  // only entries reachable by entry_index are stored
  localparam int STORE_DEPTH = (TABLE_DEPTH < ENTRY_SPAN) ? TABLE_DEPTH : ENTRY_SPAN;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam logic [COUNT_W:0]   DEPTH_C   = (COUNT_W + 1)'(TABLE_DEPTH);
  localparam logic [COUNT_W:0]   STORE_WC  = (COUNT_W + 1)'(STORE_DEPTH);
  localparam logic [CNT_W-1:0]   STORE_C   = CNT_W'(STORE_DEPTH);
  localparam logic [INDEX_W:0]   STORE_IDX = (INDEX_W + 1)'(STORE_DEPTH);

  // configuration registers
  logic [COUNT_W-1:0] active_entries;
  logic [SLAVE_W-1:0] slave_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
      slave_id       <= SLAVE_ID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_ENTRIES: active_entries <= cfg_data;
        REG_SLAVE_ID:       slave_id       <= cfg_data[SLAVE_W-1:0];
        default:            ;
      endcase
    end
  end

  // table storage
  logic [PID_W-1:0]   pid_mem   [STORE_DEPTH];
  logic [OWNER_W-1:0] owner_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] nonzero;
  logic [STORE_DEPTH-1:0] owner_set;

  op_t              in_op;
  logic             in_range;
  logic [IDX_W-1:0] wr_idx;

  assign in_op    = op_t'(operation);
  assign in_range = {1'b0, entry_index} < STORE_IDX;
  assign wr_idx   = entry_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_range && in_op == OP_LOAD_MAP) begin
      pid_mem[wr_idx] <= map_word[PID_W+7:8];
    end
    if (cmd.accept && in_range && in_op == OP_LOAD_OWNER) begin
      owner_mem[wr_idx] <= owner_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero   <= '0;
      owner_set <= '0;
    end else if (cmd.accept && in_range) begin
      if (in_op == OP_LOAD_MAP) begin
        nonzero[wr_idx] <= (map_word != '0);
      end
      if (in_op == OP_LOAD_OWNER) begin
        owner_set[wr_idx] <= 1'b1;
      end
    end
  end

  // lookup setup
  logic [COUNT_W:0] count_eff;
  logic [CNT_W-1:0] limit_in;

  always_comb begin
    if (active_entries == '0 || {1'b0, active_entries} > DEPTH_C) begin
      count_eff = DEPTH_C;
    end else begin
      count_eff = {1'b0, active_entries};
    end
    if (count_eff > STORE_WC) begin
      limit_in = STORE_C;
    end else begin
      limit_in = count_eff[CNT_W-1:0];
    end
  end

  op_t          op_q;
  logic [PID_W-1:0] pid_q;
  logic [7:0]   addr_lo;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt;

  // registered read of one entry
  logic             rd_valid;
  logic [IDX_W-1:0] rd_index;
  logic [PID_W-1:0] rd_pid;
  logic [OWNER_W-1:0] rd_owner;
  logic             rd_nz;
  logic             rd_own_set;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             first_found;
  logic [IDX_W-1:0] first_idx;

  logic match;
  logic owner_free;

  assign match      = rd_valid && !hit && rd_nz && (rd_pid == pid_q);
  assign owner_free = !rd_own_set || (rd_owner == '0);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= in_op;
      pid_q   <= {slave_id, register_address[15:8]};
      addr_lo <= register_address[7:0];
      limit   <= limit_in;
    end
    if (cmd.issue) begin
      rd_index   <= cnt[IDX_W-1:0];
      rd_pid     <= pid_mem[cnt[IDX_W-1:0]];
      rd_owner   <= owner_mem[cnt[IDX_W-1:0]];
      rd_nz      <= nonzero[cnt[IDX_W-1:0]];
      rd_own_set <= owner_set[cnt[IDX_W-1:0]];
    end
    if (match && !first_found) begin
      first_idx <= rd_index;
    end
    if (match && owner_free) begin
      hit_idx <= rd_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      rd_valid    <= 1'b0;
      hit         <= 1'b0;
      first_found <= 1'b0;
    end else if (cmd.accept) begin
      cnt         <= '0;
      rd_valid    <= 1'b0;
      hit         <= 1'b0;
      first_found <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.issue) begin
        cnt <= cnt + 1'b1;
      end
      if (match) begin
        first_found <= 1'b1;
      end
      if (match && owner_free) begin
        hit <= 1'b1;
      end
    end
  end

  // result selection
  logic               lookup_q;
  logic               take;
  logic [IDX_W-1:0]   chosen;
  logic [INDEX_W-1:0] chosen_ext;
  logic [STATUS_W-1:0]  res_status;
  logic [WORD_W-1:0]  res_addr;
  logic [CMD_W-1:0]   res_cmd;
  logic [CMD_W-1:0]   lo_field;

  assign lookup_q   = (op_q == OP_READ) || (op_q == OP_WRITE);
  assign chosen     = hit ? hit_idx : first_idx;
  assign chosen_ext = INDEX_W'(chosen);
  assign lo_field   = CMD_W'({addr_lo, {ADDR_LO_BIT{1'b0}}});

  always_comb begin
    take       = hit || (first_found && op_q == OP_READ);
    res_status = STATUS_OK;
    res_addr   = '0;
    res_cmd    = '0;
    if (lookup_q) begin
      if (!take) begin
        res_status = (op_q == OP_WRITE) ? STATUS_DENIED : STATUS_NOT_FOUND;
      end else if (op_q == OP_WRITE) begin
        res_addr = WRITE_BASE + (WORD_W'(chosen_ext) << WRITE_SHIFT);
        res_cmd  = lo_field;
      end else begin
        res_addr = READ_BASE + (WORD_W'(chosen_ext) << READ_SHIFT);
        res_cmd  = lo_field | (CMD_W'(1) << OPCODE_BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status          <= res_status;
      found_index     <= (lookup_q && take) ? chosen_ext : '0;
      channel_address <= res_addr;
      command_word    <= res_cmd;
    end
  end

  assign stat.in_is_lookup = (in_op == OP_READ) || (in_op == OP_WRITE);
  assign stat.issue_done   = (cnt == limit);
  assign stat.hit          = hit;
  assign stat.rd_pending   = rd_valid;
  assign stat.out_free     = !out_valid || !out_stall;

endmodule

// File: hw/rtl/pmic_arbiter_channel_lookup_top.sv
// channel lookup for a peripheral bus arbiter
// input channel (in_valid / in_stall) carries one item per transfer: a map
// entry load, an owner entry load, or a read or write lookup of a register
// address. every item gives exactly one result on the output channel
// (out_valid / out_stall).
// loads write the table in the cycle of the transfer; their result is
// captured once the output register is free. a lookup reads one table
// entry per cycle from the table memory, starting at entry 0, and stops
// at the first matching entry whose owner is zero or at the end of the
// active range (at most 128 entries). its result is captured after the
// last entry read has been judged and the output register is free.
// one item is worked on at a time; the next item is taken as soon as the
// current result sits in the output register, even while it is stalled.
// a stalled result holds the output register and the next finished item
// waits until it is taken.
// reset clears the configuration registers (active_entries 0, slave_id 2),
// the entry valid flags and the owner flags, so the table reads as empty
// right away with no clearing pass. configuration writes land at once.
module pmic_arbiter_channel_lookup_top
  import pacl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [WORD_W-1:0]    map_word,
  input  logic [OWNER_W-1:0]   owner_code,
  input  logic [ADDR_W-1:0]    register_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [INDEX_W-1:0]   found_index,
  output logic [WORD_W-1:0]    channel_address,
  output logic [CMD_W-1:0]     command_word
);

  cmd_t  cmd;
  stat_t stat;

  pacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pacl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .operation        (operation),
    .entry_index      (entry_index),
    .map_word         (map_word),
    .owner_code       (owner_code),
    .register_address (register_address),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .found_index      (found_index),
    .channel_address  (channel_address),
    .command_word     (command_word)
  );

endmodule

// File: hw/rtl/pacl_checker.sv
`include "pmic_arbiter_channel_lookup_top_macros.svh"

module pacl_checker
  import pacl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [INDEX_W-1:0]  found_index,
  input logic [WORD_W-1:0]   channel_address,
  input logic [CMD_W-1:0]    command_word
);

  `PACL_ASSERT_RST(a_reset_empty, rst |=> !out_valid)

  `PACL_ASSERT(a_stall_keeps_valid, out_valid && out_stall |=> out_valid)

  `PACL_ASSERT(a_stall_keeps_result, out_valid && out_stall |=> $stable(status) && $stable(channel_address))

  // failed lookups carry no channel
  `PACL_ASSERT(a_fail_zero, out_valid && status != STATUS_OK |-> found_index == '0 && channel_address == '0 && command_word == '0)

  // channel bases are stride aligned and the command low nibble is clear
  `PACL_ASSERT(a_ok_aligned, out_valid && status == STATUS_OK |-> channel_address[6:0] == '0 && command_word[3:0] == '0)

endmodule

bind pmic_arbiter_channel_lookup_top pacl_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .found_index     (found_index),
  .channel_address (channel_address),
  .command_word    (command_word)
);

// File: test/pmic_arbiter_channel_lookup_top_test.sv
`timescale 1ns / 100ps

module pmic_arbiter_channel_lookup_top_test;
  import pacl_pkg::*;

  localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] found;
    logic [WORD_W-1:0]  chan;
    logic [CMD_W-1:0]   cmd;
  } channel_res_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_value;
    op_t                  op;
    logic [INDEX_W-1:0]   idx;
    logic [WORD_W-1:0]    word;
    logic [OWNER_W-1:0]   owner;
    logic [ADDR_W-1:0]    addr;
    logic                 typed;
    channel_res_t         want;
  } access_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      operation;
  logic [INDEX_W-1:0]   entry_index;
  logic [WORD_W-1:0]    map_word;
  logic [OWNER_W-1:0]   owner_code;
  logic [ADDR_W-1:0]    register_address;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   found_index;
  logic [WORD_W-1:0]    channel_address;
  logic [CMD_W-1:0]     command_word;

  // shadow of the channel table and registers
  logic [PID_W-1:0]   shadow_pid [DEPTH];
  bit                 shadow_used [DEPTH];
  logic [OWNER_W-1:0] shadow_owner [DEPTH];
  logic [COUNT_W-1:0] shadow_active;
  logic [SLAVE_W-1:0] shadow_slave;

  channel_res_t due_results[$];
  logic         drive_typed;
  channel_res_t drive_want;
  logic [7:0]   hi_pool [3];
  int           send_mode;
  int           recv_mode;
  int           errors;
  int           checked;
  int           n_loads;
  int           n_lookups;
  int           n_hits;
  int           n_misses;
  int           n_denied;
  int           n_settings;
  int           cycles;

  pmic_arbiter_channel_lookup_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .entry_index      (entry_index),
    .map_word         (map_word),
    .owner_code       (owner_code),
    .register_address (register_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .found_index      (found_index),
    .channel_address  (channel_address),
    .command_word     (command_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic channel_res_t resolve_access(op_t op, logic [INDEX_W-1:0] idx,
                                                  logic [WORD_W-1:0] word,
                                                  logic [OWNER_W-1:0] owner,
                                                  logic [ADDR_W-1:0] addr);
    channel_res_t     r;
    int               scan_n;
    int               first;
    int               pick;
    int               i;
    logic [PID_W-1:0] pid;
    r = '0;
    first = -1;
    pick = -1;
    scan_n = (shadow_active == 0 || shadow_active > DEPTH) ? DEPTH : int'(shadow_active);
    pid = {shadow_slave, addr[15:8]};
    case (op)
      OP_LOAD_MAP: begin
        shadow_pid[idx] = word[19:8];
        shadow_used[idx] = (word != '0);
      end
      OP_LOAD_OWNER: begin
        shadow_owner[idx] = owner;
      end
      default: begin
        // first owner-zero match wins, reads fall back to the first match
        for (i = 0; i < scan_n && pick < 0; i++) begin
          if (shadow_used[i] && shadow_pid[i] == pid) begin
            if (first < 0) first = i;
            if (shadow_owner[i] == '0) pick = i;
          end
        end
        if (pick < 0 && op == OP_READ) pick = first;
        if (pick < 0) begin
          r.status = (op == OP_WRITE) ? STATUS_DENIED : STATUS_NOT_FOUND;
        end else begin
          r.found = pick[INDEX_W-1:0];
          r.cmd = CMD_W'(addr[7:0]) << ADDR_LO_BIT;
          if (op == OP_WRITE) begin
            r.chan = WRITE_BASE + (WORD_W'(pick) << WRITE_SHIFT);
          end else begin
            r.chan = READ_BASE + (WORD_W'(pick) << READ_SHIFT);
            r.cmd[OPCODE_BIT] = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic access_row_t access_row(op_t op, logic [INDEX_W-1:0] idx,
                                             logic [WORD_W-1:0] word,
                                             logic [OWNER_W-1:0] owner,
                                             logic [ADDR_W-1:0] addr);
    access_row_t r;
    r = '0;
    r.op = op;
    r.idx = idx;
    r.word = word;
    r.owner = owner;
    r.addr = addr;
    return r;
  endfunction

  // result obvious at a glance: status given, all other fields zero
  function automatic access_row_t known_row(op_t op, logic [INDEX_W-1:0] idx,
                                            logic [WORD_W-1:0] word,
                                            logic [OWNER_W-1:0] owner,
                                            logic [ADDR_W-1:0] addr, status_t st);
    access_row_t r;
    r = access_row(op, idx, word, owner, addr);
    r.typed = 1'b1;
    r.want.status = st;
    return r;
  endfunction

  function automatic access_row_t reg_row(logic [CFG_IDX_W-1:0] index,
                                          logic [CFG_DAT_W-1:0] value);
    access_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_index = index;
    r.reg_value = value;
    return r;
  endfunction

  function automatic access_row_t random_access(int span);
    access_row_t      r;
    int               roll;
    logic [7:0]       hi;
    logic [PID_W-1:0] pid;
    r = '0;
    roll = $urandom_range(0, 99);
    hi = hi_pool[$urandom_range(0, 2)];
    pid = {shadow_slave, hi};
    if ($urandom_range(0, 4) == 0) begin
      r.idx = INDEX_W'($urandom_range(0, DEPTH - 1));
    end else begin
      r.idx = INDEX_W'($urandom_range(0, span - 1));
    end
    r.owner = ($urandom_range(0, 2) == 0) ? '0 : OWNER_W'($urandom_range(0, 7));
    r.word = $urandom;
    r.addr = {hi, 8'($urandom_range(0, 255))};
    if (roll < 30) begin
      r.op = OP_LOAD_MAP;
      // mostly ids that lookups of this phase will hit
      if (roll < 24) begin
        r.word[19:8] = pid;
      end else if (roll < 26) begin
        r.word = '0;
      end
    end else if (roll < 50) begin
      r.op = OP_LOAD_OWNER;
    end else begin
      r.op = roll[0] ? OP_WRITE : OP_READ;
      if ($urandom_range(0, 6) == 0) r.addr = ADDR_W'($urandom);
    end
    return r;
  endfunction

  function automatic int draw_gap(int mode);
    int g;
    case (mode)
      0: g = 0;
      1: g = $urandom_range(0, 19);
      default: g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
    endcase
    return g;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic send_access(access_row_t row);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= row.op;
    entry_index <= row.idx;
    map_word <= row.word;
    owner_code <= row.owner;
    register_address <= row.addr;
    in_valid <= 1'b1;
    drive_typed = row.typed;
    drive_want = row.want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
    in_valid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index == REG_ACTIVE_ENTRIES) begin
      shadow_active = value;
    end else begin
      shadow_slave = value[SLAVE_W-1:0];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_transfers
    channel_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d index %0d address 0x%0h",
                   $time, status, found_index, channel_address);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, status);
          check_field("found_index", want.found, found_index);
          check_field("channel_address", want.chan, channel_address);
          check_field("command_word", want.cmd, command_word);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want = resolve_access(op_t'(operation), entry_index, map_word, owner_code,
                              register_address);
        if (drive_typed) want = drive_want;
        due_results.push_back(want);
        if (operation == OP_LOAD_MAP || operation == OP_LOAD_OWNER) begin
          n_loads++;
        end else begin
          n_lookups++;
          case (want.status)
            STATUS_OK:        n_hits++;
            STATUS_NOT_FOUND: n_misses++;
            default:          n_denied++;
          endcase
        end
      end
    end
  end

  initial begin : take_results
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = draw_gap(recv_mode);
      // hold the stall across an offered result
      if (gap > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: no finish after %0d cycles", $time, cycles);
    $display("FAIL pmic_arbiter_channel_lookup_top");
    $finish;
  end

  initial begin : stimulus
    access_row_t          plan[$];
    logic [CFG_DAT_W-1:0] val;
    int                   sent;
    int                   span;
    int                   k;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_LOAD_MAP;
    entry_index = '0;
    map_word = '0;
    owner_code = '0;
    register_address = '0;
    drive_typed = 1'b0;
    drive_want = '0;
    send_mode = 1;
    recv_mode = 1;
    errors = 0;
    checked = 0;
    n_loads = 0;
    n_lookups = 0;
    n_hits = 0;
    n_misses = 0;
    n_denied = 0;
    n_settings = 0;
    sent = 0;
    for (k = 0; k < DEPTH; k++) begin
      shadow_pid[k] = '0;
      shadow_used[k] = 1'b0;
      shadow_owner[k] = '0;
    end
    shadow_active = '0;
    shadow_slave = SLAVE_ID_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table after reset, full depth, slave id 2
    plan.push_back(known_row(OP_READ, 7'd0, 32'h0, 3'd0, 16'h0000, STATUS_NOT_FOUND));
    plan.push_back(known_row(OP_WRITE, 7'd127, '1, 3'd7, 16'hFFFF, STATUS_DENIED));
    plan.push_back(known_row(OP_LOAD_MAP, 7'd0, 32'h0, 3'd0, 16'h0000, STATUS_OK));
    plan.push_back(known_row(OP_LOAD_MAP, 7'd127, '1, 3'd7, 16'hFFFF, STATUS_OK));
    plan.push_back(known_row(OP_LOAD_OWNER, 7'd127, 32'h0, 3'd7, 16'h0000, STATUS_OK));
    plan.push_back(access_row(OP_LOAD_MAP, 7'd5, 32'h0002_3400, 3'd0, 16'h0000));
    plan.push_back(access_row(OP_LOAD_OWNER, 7'd5, 32'h0, 3'd3, 16'h0000));
    plan.push_back(access_row(OP_LOAD_MAP, 7'd9, 32'hFFF2_34FF, 3'd0, 16'h0000));
    // read and write both take the owner-zero entry over an earlier non-zero owner match
    plan.push_back(access_row(OP_READ, 7'd0, 32'h0, 3'd0, 16'h34AB));
    plan.push_back(access_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'h34AB));
    plan.push_back(access_row(OP_LOAD_OWNER, 7'd9, 32'h0, 3'd1, 16'h0000));
    plan.push_back(access_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'h3400));
    plan.push_back(reg_row(REG_SLAVE_ID, CFG_DAT_W'(15)));
    plan.push_back(access_row(OP_READ, 7'd0, 32'h0, 3'd0, 16'hFF00));
    plan.push_back(access_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'hFFFF));
    plan.push_back(access_row(OP_LOAD_OWNER, 7'd127, 32'h0, 3'd0, 16'h0000));
    plan.push_back(access_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'hFFFF));
    // last entry falls outside the scan
    plan.push_back(reg_row(REG_ACTIVE_ENTRIES, CFG_DAT_W'(127)));
    plan.push_back(access_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'hFFFF));
    plan.push_back(reg_row(REG_ACTIVE_ENTRIES, CFG_DAT_W'(2047)));
    plan.push_back(access_row(OP_READ, 7'd0, 32'h0, 3'd0, 16'hFFFF));
    // a zero map word never matches, even for peripheral id zero
    plan.push_back(reg_row(REG_SLAVE_ID, CFG_DAT_W'(0)));
    plan.push_back(known_row(OP_READ, 7'd0, 32'h0, 3'd0, 16'h0000, STATUS_NOT_FOUND));
    plan.push_back(known_row(OP_WRITE, 7'd0, 32'h0, 3'd0, 16'h00FF, STATUS_DENIED));
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_access(plan[i]);
      end
    end
    n_settings = 1;

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: val = '0;
        1: val = CFG_DAT_W'(2047);
        2: val = CFG_DAT_W'($urandom_range(DEPTH - 1, DEPTH + 1));
        3: val = CFG_DAT_W'($urandom_range(1, 8));
        4: val = CFG_DAT_W'($urandom_range(1, 2047));
        default: val = CFG_DAT_W'($urandom_range(1, 40));
      endcase
      write_reg(REG_ACTIVE_ENTRIES, val);
      val = CFG_DAT_W'($urandom);
      case ($urandom_range(0, 3))
        0: val[SLAVE_W-1:0] = '0;
        1: val[SLAVE_W-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_SLAVE_ID, val);
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          hi_pool[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
          hi_pool[k] = 8'($urandom_range(0, 255));
        end
      end
      span = (shadow_active == 0 || shadow_active > DEPTH) ? DEPTH : int'(shadow_active);
      repeat ($urandom_range(40, 120)) begin
        send_access(random_access(span));
        sent++;
      end
      n_settings++;
    end

    in_valid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results across %0d register settings: %0d table loads, %0d lookups",
             checked, n_settings, n_loads, n_lookups);
    $display("lookups found %0d, read misses %0d, write denials %0d; %0d mismatches",
             n_hits, n_misses, n_denied, errors);
    if (errors == 0) begin
      $display("PASS pmic_arbiter_channel_lookup_top");
    end else begin
      $display("FAIL pmic_arbiter_channel_lookup_top");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pacl_pkg.sv
hw/rtl/pacl_ctrl.sv
hw/rtl/pacl_datapath.sv
hw/rtl/pmic_arbiter_channel_lookup_top.sv
hw/rtl/pacl_checker.sv
test/pmic_arbiter_channel_lookup_top_test.sv
